/* rtl/core/oaht_pkg.sv */
// shared constants, codes and types of the open-addressing hash table unit
// no dependencies; imported by the remainder unit, the probe engine and the top level
`timescale 1ns / 1ps

package oaht_pkg;

   // table geometry
   localparam int MAX_SLOTS = 256;
   localparam int KEY_BYTES = 8;

   // derived widths
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int SIZE_W    = $clog2(MAX_SLOTS + 1);
   localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int REM_W     = SLOT_W + 1;
   localparam int SUM_W     = $clog2(KEY_BYTES * 255 + 1);
   localparam int MOD_STEPS = (SUM_W + 1) / 2;
   localparam int DIV_W     = 2 * MOD_STEPS;
   localparam int MSTEP_W   = $clog2(MOD_STEPS + 1);

   // field widths
   localparam int OP_W       = 2;
   localparam int KEY_W      = 64;
   localparam int VAL_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int ENTRY_W    = 9;
   localparam int KV_W       = KEY_W + VAL_W;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int SLOT_ST_W  = 2;

   // request opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // result codes
   localparam logic [STATUS_W-1:0] RES_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] RES_FULL      = 2'd2;

   // slot states
   localparam logic [SLOT_ST_W-1:0] ST_EMPTY   = 2'd0;
   localparam logic [SLOT_ST_W-1:0] ST_USED    = 2'd1;
   localparam logic [SLOT_ST_W-1:0] ST_DELETED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE = 2'd1;

   // engine sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_HASH,
      S_PROBE
   } eng_state_type;

   // live configuration seen by the engine
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              probe_mode;
   } cfg_type;

   // remainder unit request and response
   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] rem;
   } mod_rsp_type;

   // live count onto the fixed-width result field, saturating
   function automatic logic [ENTRY_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
      logic [ENTRY_W-1:0] r;
      if (32'(c) > 32'd511) begin
         r = 9'd511;
      end else begin
         r = ENTRY_W'(c);
      end
      return r;
   endfunction

endpackage

/* rtl/core/oaht_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/oaht_mod_unit.sv */
// iterative remainder unit: key byte sum modulo table size, two bits a cycle
// depends on oaht_pkg
`timescale 1ns / 1ps

module oaht_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  oaht_pkg::mod_req_type mod_req,
   output oaht_pkg::mod_rsp_type mod_rsp
);

   import oaht_pkg::*;

   logic [DIV_W-1:0]   quot_ff, quot_in;
   logic [SLOT_W-1:0]  rem_ff, rem_in;
   logic [SIZE_W-1:0]  divisor_ff, divisor_in;
   logic [MSTEP_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // two restoring steps per cycle on the top dividend bits
   always_comb begin
      logic [REM_W-1:0] t;
      logic [SLOT_W-1:0] r;
      t          = '0;
      r          = rem_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (mod_req.start) begin
         quot_in    = DIV_W'(mod_req.dividend);
         rem_in     = '0;
         divisor_in = mod_req.divisor;
         cnt_in     = MSTEP_W'(MOD_STEPS);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            t = {r, quot_ff[DIV_W-1-i]};
            if (t >= REM_W'(divisor_ff)) begin
               t = t - REM_W'(divisor_ff);
            end
            r = t[SLOT_W-1:0];
         end
         rem_in  = r;
         quot_in = {quot_ff[DIV_W-3:0], 2'b00};
         cnt_in  = cnt_ff - MSTEP_W'(1);
         if (cnt_ff == MSTEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

endmodule

/* rtl/core/oaht_probe_engine.sv */
// probe sequencer: slot rams, status valid bits, live count and result register
// depends on oaht_pkg and oaht_ram
`timescale 1ns / 1ps

module oaht_probe_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  oaht_pkg::cfg_type                cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [oaht_pkg::OP_W-1:0]        req_op,
   input  logic [oaht_pkg::KEY_W-1:0]       req_key,
   input  logic [oaht_pkg::VAL_W-1:0]       req_value,
   input  logic [oaht_pkg::SUM_W-1:0]       req_sum,
   output oaht_pkg::mod_req_type            mod_req,
   input  oaht_pkg::mod_rsp_type            mod_rsp,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [oaht_pkg::STATUS_W-1:0]    rsp_status,
   output logic [oaht_pkg::VAL_W-1:0]       rsp_value,
   output logic [oaht_pkg::ENTRY_W-1:0]     rsp_count
);

   import oaht_pkg::*;

   eng_state_type      state_ff, state_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0]  step_ff, step_in;
   logic [SIZE_W-1:0]  n_ff, n_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [COUNT_W-1:0] live_ff, live_in;
   logic [MAX_SLOTS-1:0] slot_valid_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [ENTRY_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 st_we;
   logic [SLOT_ST_W-1:0] st_wdata;
   logic [SLOT_ST_W-1:0] st_rdata;
   logic                 kv_we;
   logic [KV_W-1:0]      kv_rdata;

   logic                 out_free;
   logic                 finish;
   logic [SLOT_ST_W-1:0] slot_st;
   logic                 key_hit;
   logic                 last_probe;
   logic [SIZE_W-1:0]    n_inc;
   logic [SLOT_W-1:0]    idx_next;
   logic [SLOT_W-1:0]    step_next;
   logic [SLOT_W-1:0]    step_init;

   // slot state and slot contents
   oaht_ram #(.WIDTH(SLOT_ST_W), .DEPTH(MAX_SLOTS)) u_status_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (idx_ff),
      .wr_data (st_wdata),
      .rd_addr (idx_in),
      .rd_data (st_rdata)
   );

   oaht_ram #(.WIDTH(KV_W), .DEPTH(MAX_SLOTS)) u_kv_ram (
      .clock   (clock),
      .wr_en   (kv_we),
      .wr_addr (idx_ff),
      .wr_data ({key_ff, val_ff}),
      .rd_addr (idx_in),
      .rd_data (kv_rdata)
   );

   // probe index walk: index moves by step, step grows by two when quadratic
   always_comb begin
      logic [REM_W-1:0] s;
      logic [REM_W-1:0] d;
      s = REM_W'(idx_ff) + REM_W'(step_ff);
      if (s >= REM_W'(cfg.size)) begin
         s = s - REM_W'(cfg.size);
      end
      idx_next = s[SLOT_W-1:0];
      d = REM_W'(step_ff) + REM_W'(2);
      if (d >= REM_W'(cfg.size)) begin
         d = d - REM_W'(cfg.size);
      end
      if (d >= REM_W'(cfg.size)) begin
         d = d - REM_W'(cfg.size);
      end
      step_next = cfg.probe_mode ? d[SLOT_W-1:0] : step_ff;
      step_init = (cfg.size == SIZE_W'(1)) ? SLOT_W'(0) : SLOT_W'(1);
   end

   // slot seen by the current probe
   assign slot_st    = slot_valid_ff[idx_ff] ? st_rdata : ST_EMPTY;
   assign key_hit    = (kv_rdata[KV_W-1:VAL_W] == key_ff);
   assign n_inc      = n_ff + SIZE_W'(1);
   assign last_probe = (n_inc == cfg.size);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      n_in          = n_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      live_in       = live_ff;
      st_we         = 1'b0;
      st_wdata      = ST_USED;
      kv_we         = 1'b0;
      finish        = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      req_ready     = 1'b0;
      mod_req.start    = 1'b0;
      mod_req.dividend = req_sum;
      mod_req.divisor  = cfg.size;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            mod_req.start = req_valid;
            if (req_valid) begin
               op_in    = req_op;
               key_in   = req_key;
               val_in   = req_value;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (mod_rsp.done) begin
               idx_in   = mod_rsp.rem;
               step_in  = step_init;
               n_in     = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (out_free) begin
               rsp_value_in = '0;
               if (op_ff == OP_INSERT) begin
                  // first free or tombstoned slot takes the entry
                  if (slot_st != ST_USED) begin
                     st_we         = 1'b1;
                     kv_we         = 1'b1;
                     live_in       = live_ff + COUNT_W'(1);
                     rsp_status_in = RES_DONE;
                     finish        = 1'b1;
                  end else if (last_probe) begin
                     rsp_status_in = RES_FULL;
                     finish        = 1'b1;
                  end
               end else begin
                  // delete and lookup stop at an empty slot, a match or the last probe
                  if (slot_st == ST_EMPTY) begin
                     rsp_status_in = RES_NOT_FOUND;
                     finish        = 1'b1;
                  end else if (slot_st == ST_USED && key_hit) begin
                     rsp_status_in = RES_DONE;
                     finish        = 1'b1;
                     if (op_ff == OP_DELETE) begin
                        st_we    = 1'b1;
                        st_wdata = ST_DELETED;
                        if (live_ff != '0) begin
                           live_in = live_ff - COUNT_W'(1);
                        end
                     end else begin
                        rsp_value_in = kv_rdata[VAL_W-1:0];
                     end
                  end else if (last_probe) begin
                     rsp_status_in = RES_NOT_FOUND;
                     finish        = 1'b1;
                  end
               end
               if (finish) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_next;
                  step_in = step_next;
                  n_in    = n_inc;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_count_in = rsp_count_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = sat_count(live_in);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_ff       <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_we) begin
            slot_valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      n_ff          <= n_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

/* rtl/core/open_addressing_hash_table_unit.sv */
// top level of the open-addressing hash table unit: ports, registers, key framing
// depends on oaht_pkg, oaht_mod_unit and oaht_probe_engine
`timescale 1ns / 1ps

// Open-addressing hash table of up to 256 slots holding 64-bit keys and 32-bit
// values. Each request transfer (opcode in req_tuser: insert, delete or lookup)
// yields one response transfer with a status in rsp_tuser and the read value and
// live entry count in rsp_tdata. The key ends at its first zero byte; the home
// slot is the byte sum modulo table_size, and probing is linear or quadratic as
// probe_mode selects. Requests are handled one at a time: after a transfer the
// remainder unit finds the home slot two quotient bits a cycle, the sequencer
// then hands it to the slot memories, and the probes follow, a slot read per
// cycle while the output register is free, with the next address issued while
// the current slot is checked. A response still waiting in the output
// register holds every probe cycle of the next request until it is taken, so
// its wait adds to that request's latency; the next request itself is still
// taken meanwhile. Slot states are cleared at reset at once through per-slot
// valid bits; there is no clearing pass.
// Configuration writes are always taken and must only be issued while idle.

module open_addressing_hash_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = key[63:0], value[95:64]; tuser = opcode[1:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [oaht_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [oaht_pkg::OP_W-1:0]           req_tuser,
   // response: tdata = read_value[31:0], entry_count[40:32], zero[47:41];
   // tuser = status[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [oaht_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [oaht_pkg::STATUS_W-1:0]       rsp_tuser,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [oaht_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [oaht_pkg::CSR_DATA_W-1:0]     csr_data
);

   import oaht_pkg::*;

   logic [8:0]         table_size_ff;
   logic               probe_mode_ff;
   cfg_type            cfg;
   logic [KEY_W-1:0]   key_norm;
   logic [SUM_W-1:0]   key_sum;
   mod_req_type        mod_req;
   mod_rsp_type        mod_rsp;
   logic [STATUS_W-1:0] rsp_status;
   logic [VAL_W-1:0]    rsp_value;
   logic [ENTRY_W-1:0]  rsp_count;

   // register writes, unknown indexes ignored
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= 9'd256;
         probe_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TABLE_SIZE: table_size_ff <= csr_data[8:0];
            CSR_PROBE_MODE: probe_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // table size clamped to one .. MAX_SLOTS
   always_comb begin
      if (table_size_ff == 9'd0) begin
         cfg.size = SIZE_W'(1);
      end else if (32'(table_size_ff) > MAX_SLOTS) begin
         cfg.size = SIZE_W'(MAX_SLOTS);
      end else begin
         cfg.size = SIZE_W'(table_size_ff);
      end
      cfg.probe_mode = probe_mode_ff;
   end

   // key bytes up to the first zero byte, and their sum
   always_comb begin
      logic       alive;
      logic [7:0] kb;
      alive    = 1'b1;
      kb       = '0;
      key_norm = '0;
      key_sum  = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         kb = req_tdata[8*b +: 8];
         if (kb == 8'd0) begin
            alive = 1'b0;
         end
         if (alive) begin
            key_norm[8*b +: 8] = kb;
            key_sum            = key_sum + SUM_W'(kb);
         end
      end
   end

   oaht_mod_unit u_mod_unit (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   oaht_probe_engine u_probe_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_key    (key_norm),
      .req_value  (req_tdata[KEY_W +: VAL_W]),
      .req_sum    (key_sum),
      .mod_req    (mod_req),
      .mod_rsp    (mod_rsp),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_count  (rsp_count)
   );

   // response packing
   assign rsp_tdata = {(RSP_DATA_W - VAL_W - ENTRY_W)'(0), rsp_count, rsp_value};
   assign rsp_tuser = rsp_status;

endmodule
